### sv/n2w_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// n2w_pkg
// Word codes, microcode word layout and the control program of the
// integer-to-words sequencer.
// ----------------------------------------------------------------------------
package n2w_pkg;

  // Widths
  localparam int ValueWidth = 32;
  localparam int CodeWidth  = 6;
  localparam int Digits     = 10;
  localparam int BcdWidth   = 4 * Digits;
  localparam int PcWidth    = 4;

  // Word codes
  localparam logic [CodeWidth-1:0] CODE_ZERO      = 6'd0;
  localparam logic [CodeWidth-1:0] CODE_TENS_BASE = 6'd18;
  localparam logic [CodeWidth-1:0] CODE_HUNDRED   = 6'd28;
  localparam logic [CodeWidth-1:0] CODE_SCALE_BASE = 6'd28;
  localparam logic [CodeWidth-1:0] CODE_NEGATIVE  = 6'd32;

  // Program step addresses
  localparam logic [PcWidth-1:0] STEP_IDLE   = 4'd0;
  localparam logic [PcWidth-1:0] STEP_CONV   = 4'd1;
  localparam logic [PcWidth-1:0] STEP_NEG    = 4'd2;
  localparam logic [PcWidth-1:0] STEP_ZERO   = 4'd3;
  localparam logic [PcWidth-1:0] STEP_HUN    = 4'd4;
  localparam logic [PcWidth-1:0] STEP_HWORD  = 4'd5;
  localparam logic [PcWidth-1:0] STEP_TENS   = 4'd6;
  localparam logic [PcWidth-1:0] STEP_UNITS  = 4'd7;
  localparam logic [PcWidth-1:0] STEP_REST   = 4'd8;
  localparam logic [PcWidth-1:0] STEP_SCALE  = 4'd9;
  localparam logic [PcWidth-1:0] STEP_FLUSH  = 4'd10;

  // Word source selected by a control word
  typedef enum logic [3:0] {
    SRC_NONE    = 4'd0,
    SRC_NEG     = 4'd1,
    SRC_ZERO    = 4'd2,
    SRC_HUN     = 4'd3,
    SRC_HUNDRED = 4'd4,
    SRC_TENS    = 4'd5,
    SRC_UNITS   = 4'd6,
    SRC_REST    = 4'd7,
    SRC_SCALE   = 4'd8
  } src_t;

  // Sequencing of the step counter
  typedef enum logic [1:0] {
    JMP_NEXT       = 2'd0,
    JMP_CONV_MORE  = 2'd1,
    JMP_GROUP_MORE = 2'd2,
    JMP_ALWAYS     = 2'd3
  } jmp_t;

  typedef struct packed {
    src_t               src;
    jmp_t               jmp;
    logic [PcWidth-1:0] target;
    logic               conv;
    logic               grp_dec;
    logic               flush;
  } ucode_t;

  // Control program
  function automatic ucode_t ucode_rom(input logic [PcWidth-1:0] pc);
    ucode_t w;
    w = '{src: SRC_NONE, jmp: JMP_ALWAYS, target: STEP_IDLE,
          conv: 1'b0, grp_dec: 1'b0, flush: 1'b0};
    unique case (pc)
      STEP_CONV: begin
        w.jmp = JMP_CONV_MORE; w.target = STEP_CONV; w.conv = 1'b1;
      end
      STEP_NEG:   begin w.src = SRC_NEG;     w.jmp = JMP_NEXT; end
      STEP_ZERO:  begin w.src = SRC_ZERO;    w.jmp = JMP_NEXT; end
      STEP_HUN:   begin w.src = SRC_HUN;     w.jmp = JMP_NEXT; end
      STEP_HWORD: begin w.src = SRC_HUNDRED; w.jmp = JMP_NEXT; end
      STEP_TENS:  begin w.src = SRC_TENS;    w.jmp = JMP_NEXT; end
      STEP_UNITS: begin w.src = SRC_UNITS;   w.jmp = JMP_NEXT; end
      STEP_REST:  begin w.src = SRC_REST;    w.jmp = JMP_NEXT; end
      STEP_SCALE: begin
        w.src = SRC_SCALE; w.jmp = JMP_GROUP_MORE; w.target = STEP_HUN;
        w.grp_dec = 1'b1;
      end
      STEP_FLUSH: begin w.flush = 1'b1; w.target = STEP_IDLE; end
      default: begin
        w.target = STEP_IDLE;
      end
    endcase
    return w;
  endfunction

  // One binary-to-BCD step: add 3 to every digit of 5 or more, then shift in a bit
  function automatic logic [BcdWidth-1:0] dabble(input logic [BcdWidth-1:0] bcd,
                                                 input logic bit_in);
    logic [BcdWidth-1:0] adj;
    adj = bcd;
    for (int i = 0; i < Digits; i++) begin
      if (bcd[4*i +: 4] >= 4'd5) begin
        adj[4*i +: 4] = bcd[4*i +: 4] + 4'd3;
      end
    end
    return {adj[BcdWidth-2:0], bit_in};
  endfunction

endpackage

### sv/number_to_word_tokens_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// number_to_word_tokens_core
// Spells a signed 32-bit integer as a run of English word codes, driven by a
// microcoded sequencer over a BCD conversion and group-spelling datapath.
// ----------------------------------------------------------------------------
// Timing: busy from the request through the flush step. The first word is
//   strobed once a second word is emitted or at the flush step, and the last
//   word is strobed in the first cycle with busy low.
// Sequence: 16 conversion steps at two bits per step, negative and zero steps,
//   six steps for each of the four digit groups, a flush step and the idle
//   step that takes the next request, so a request waits for the last to end.
// One word per strobe, strobes may be back to back; the receiver cannot stall.
// Reset: rst returns the sequencer to idle and drops any pending word.
module number_to_word_tokens_core
  import n2w_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  logic [ValueWidth-1:0]  value,
  output logic                   word_valid,
  output logic [CodeWidth-1:0]   word_code,
  output logic                   last_word
);

  // Sequencer state
  logic [PcWidth-1:0]    pc;
  logic [3:0]            cnt;
  logic [1:0]            gsel;
  ucode_t                uw;

  // Datapath state
  logic                  neg;
  logic                  zero;
  logic [ValueWidth-1:0] mag;
  logic [BcdWidth-1:0]   bcd;
  logic                  pend_valid;
  logic [CodeWidth-1:0]  pend_code;

  // Group view
  logic [3:0]            hun;
  logic [3:0]            tens;
  logic [3:0]            units;
  logic [6:0]            rest;
  logic                  grp_nz;
  logic                  emit;
  logic [CodeWidth-1:0]  code;
  logic [PcWidth-1:0]    pc_next;

  assign uw   = ucode_rom(pc);
  assign busy = (pc != STEP_IDLE);

  // Select the digits of the current three-digit group
  always_comb begin
    unique case (gsel)
      2'd3: begin hun = 4'd0; tens = 4'd0; units = bcd[39:36]; end
      2'd2: begin hun = bcd[35:32]; tens = bcd[31:28]; units = bcd[27:24]; end
      2'd1: begin hun = bcd[23:20]; tens = bcd[19:16]; units = bcd[15:12]; end
      default: begin hun = bcd[11:8]; tens = bcd[7:4]; units = bcd[3:0]; end
    endcase
  end

  assign rest   = {tens, 3'b000} + {2'b00, tens, 1'b0} + {3'b000, units};
  assign grp_nz = (hun != 4'd0) || (tens != 4'd0) || (units != 4'd0);

  // Pick the word and decide whether this step emits it
  always_comb begin
    emit = 1'b0;
    code = CODE_ZERO;
    unique case (uw.src)
      SRC_NEG:     begin emit = neg;  code = CODE_NEGATIVE; end
      SRC_ZERO:    begin emit = zero; code = CODE_ZERO; end
      SRC_HUN:     begin emit = (hun != 4'd0); code = {2'b00, hun}; end
      SRC_HUNDRED: begin emit = (hun != 4'd0); code = CODE_HUNDRED; end
      SRC_TENS: begin
        emit = (tens > 4'd1);
        code = CODE_TENS_BASE + {2'b00, tens};
      end
      SRC_UNITS: begin
        emit = (tens > 4'd1) && (units != 4'd0);
        code = {2'b00, units};
      end
      SRC_REST: begin
        emit = (tens <= 4'd1) && (rest != 7'd0);
        code = rest[CodeWidth-1:0];
      end
      SRC_SCALE: begin
        emit = grp_nz && (gsel != 2'd0);
        code = CODE_SCALE_BASE + {4'b0000, gsel};
      end
      default: begin
        emit = 1'b0;
        code = CODE_ZERO;
      end
    endcase
  end

  // Next step address
  always_comb begin
    pc_next = pc + 4'd1;
    unique case (uw.jmp)
      JMP_NEXT:       pc_next = pc + 4'd1;
      JMP_CONV_MORE:  if (cnt != 4'hF) pc_next = uw.target;
      JMP_GROUP_MORE: if (gsel != 2'd0) pc_next = uw.target;
      default:        pc_next = uw.target;
    endcase
  end

  // Advance the sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      pc         <= STEP_IDLE;
      pend_valid <= 1'b0;
      word_valid <= 1'b0;
    end else begin
      word_valid <= 1'b0;
      if (!busy) begin
        if (start) begin
          pc         <= STEP_CONV;
          pend_valid <= 1'b0;
        end
      end else begin
        pc <= pc_next;
        if (uw.flush) begin
          word_valid <= pend_valid;
          pend_valid <= 1'b0;
        end else if (emit) begin
          word_valid <= pend_valid;
          pend_valid <= 1'b1;
        end
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (!busy) begin
      if (start) begin
        neg  <= value[ValueWidth-1];
        zero <= (value == '0);
        mag  <= value[ValueWidth-1] ? (~value + 32'd1) : value;
        bcd  <= '0;
        cnt  <= 4'd0;
        gsel <= 2'd3;
      end
    end else begin
      if (uw.conv) begin
        bcd <= dabble(dabble(bcd, mag[ValueWidth-1]), mag[ValueWidth-2]);
        mag <= {mag[ValueWidth-3:0], 2'b00};
        cnt <= cnt + 4'd1;
      end
      if (uw.grp_dec) begin
        gsel <= gsel - 2'd1;
      end
      // Hold the newest word; release the older one, last set only at flush
      if (uw.flush) begin
        word_code <= pend_code;
        last_word <= 1'b1;
      end else if (emit) begin
        word_code <= pend_code;
        last_word <= 1'b0;
        pend_code <= code;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_last_gap: assert property (@(posedge clk) disable iff (rst)
    word_valid && last_word |=> !word_valid)
    else $error("word strobe right after last word");

  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("request accepted but sequencer not busy");

  a_code_range: assert property (@(posedge clk) disable iff (rst)
    word_valid |-> word_code <= CODE_NEGATIVE)
    else $error("word code out of range");

  a_idle_clean: assert property (@(posedge clk) disable iff (rst)
    !busy |-> !pend_valid)
    else $error("pending word left while idle");
`endif

endmodule

### dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for number_to_word_tokens_core. A queue-fed driver
// issues signed 32-bit requests and a monitor predicts the spelled word run
// for each accepted request. It then checks every strobed word, in order,
// against that prediction.
// ----------------------------------------------------------------------------
module testbench;
  import n2w_pkg::*;

  localparam int ClkHalf     = 5;
  localparam int ResetCycles = 9;
  localparam int TailCycles  = 60;
  localparam int CycleLimit  = 250000;

  typedef struct packed {
    logic [CodeWidth-1:0] code;
    logic                 last;
  } word_t;

  logic                  clk   = 1'b0;
  logic                  rst   = 1'b1;
  logic                  start = 1'b0;
  logic                  busy;
  logic [ValueWidth-1:0] value = '0;
  logic                  word_valid;
  logic [CodeWidth-1:0]  word_code;
  logic                  last_word;

  logic [ValueWidth-1:0] pending_values[$];
  word_t                 expected_words[$];
  int                    queued_count   = 0;
  int                    issued_count   = 0;
  int                    accepted_count = 0;
  int                    mismatch_count = 0;
  int                    idle_pct       = 0;
  int                    cycle_count    = 0;

  number_to_word_tokens_core u_dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .value      (value),
    .word_valid (word_valid),
    .word_code  (word_code),
    .last_word  (last_word)
  );

  // Toggle the clock: high, then low
  always begin
    #ClkHalf clk = 1'b1;
    #ClkHalf clk = 1'b0;
  end

  // Spell one value and append its expected word run
  function automatic void spell_value(input logic [ValueWidth-1:0] v);
    logic [CodeWidth-1:0]  codes[$];
    logic [ValueWidth-1:0] mag;
    int unsigned           grp[4];
    int unsigned           hun;
    int unsigned           rest;
    int unsigned           tens;
    int unsigned           units;
    mag = v;
    if (v[ValueWidth-1]) begin
      codes.push_back(CODE_NEGATIVE);
      mag = '0 - v;
    end
    if (mag == '0) begin
      codes.push_back(CODE_ZERO);
    end else begin
      for (int g = 0; g < 4; g++) begin
        grp[g] = mag % 1000;
        mag    = mag / 1000;
      end
      for (int g = 3; g >= 0; g--) begin
        if (grp[g] != 0) begin
          hun   = grp[g] / 100;
          rest  = grp[g] % 100;
          tens  = rest / 10;
          units = rest % 10;
          if (hun > 0) begin
            codes.push_back(CodeWidth'(hun));
            codes.push_back(CODE_HUNDRED);
          end
          if (tens > 1) begin
            codes.push_back(CODE_TENS_BASE + CodeWidth'(tens));
            if (units > 0) begin
              codes.push_back(CodeWidth'(units));
            end
          end else if (rest > 0) begin
            codes.push_back(CodeWidth'(rest));
          end
          // thousand, million, billion follow the scale base
          if (g > 0) begin
            codes.push_back(CODE_SCALE_BASE + CodeWidth'(g));
          end
        end
      end
    end
    foreach (codes[i]) begin
      expected_words.push_back('{code: codes[i], last: (i == codes.size() - 1)});
    end
  endfunction

  task automatic report_mismatch(input string what, input int unsigned want,
                                 input int unsigned got);
    $display("[%0t] %s: expected %0d, got %0d", $time, what, want, got);
    mismatch_count++;
  endtask

  // Check strobed words, then predict any request taken at this edge
  always @(posedge clk) begin
    if (!rst) begin
      if (word_valid) begin
        if (expected_words.size() == 0) begin
          report_mismatch("word with no request outstanding", 0, word_code);
        end else begin
          if (word_code !== expected_words[0].code) begin
            report_mismatch("word_code", expected_words[0].code, word_code);
          end
          if (last_word !== expected_words[0].last) begin
            report_mismatch("last_word", expected_words[0].last, last_word);
          end
          void'(expected_words.pop_front());
        end
      end
      if (start && !busy) begin
        spell_value(value);
        accepted_count++;
      end
    end
  end

  // Issue requests from the pending queue, idling at random
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (start && accepted_count != issued_count) begin
      // hold the request until it is taken
    end else if (pending_values.size() != 0 && $urandom_range(99) >= idle_pct) begin
      value <= pending_values.pop_front();
      start <= 1'b1;
      issued_count++;
    end else begin
      start <= 1'b0;
    end
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic queue_value(input logic [ValueWidth-1:0] v);
    pending_values.push_back(v);
    queued_count++;
  endtask

  // Wait until every request is taken and every word has come back
  task automatic wait_drained();
    while (accepted_count != queued_count || expected_words.size() != 0) begin
      @(negedge clk);
    end
  endtask

  // Three-digit group, zero a third of the time
  function automatic int unsigned sparse_group();
    return ($urandom_range(2) == 0) ? 0 : $urandom_range(999);
  endfunction

  function automatic logic [ValueWidth-1:0] random_value();
    logic [ValueWidth-1:0] v;
    int unsigned           sel;
    sel = $urandom_range(3);
    case (sel)
      0: v = $urandom();
      1: v = $urandom_range(999);
      2: v = $urandom_range(1) * 32'd1000000000 + sparse_group() * 32'd1000000
             + sparse_group() * 32'd1000 + sparse_group();
      default: v = 32'h7FFF_FFFF - $urandom_range(2000);
    endcase
    if (sel != 0 && $urandom_range(1) == 1) begin
      v = '0 - v;
    end
    return v;
  endfunction

  task automatic run_random_phase(input int pct, input int count);
    idle_pct = pct;
    repeat (count) begin
      queue_value(random_value());
    end
    wait_drained();
  endtask

  initial begin
    logic [ValueWidth-1:0] directed[25] = '{
      0, 1, -1, 12, 19, 20, 21, 99, 100, 101, 110, 999, 1000, 1001,
      1000000, 1000000000, 2147483647, 32'h8000_0000, 1013014015, 16017018,
      123456789, -987654321, 500000, 80000000, 305070090
    };
    repeat (ResetCycles) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: extremes, teens, tens, zero groups, every scale word
    idle_pct = 0;
    foreach (directed[i]) begin
      queue_value(directed[i]);
    end
    wait_drained();

    // Random: back to back, sparse sender, back to back, mixed idling
    run_random_phase(0, 110);
    run_random_phase(54, 110);
    run_random_phase(0, 105);
    run_random_phase(37, 110);

    repeat (TailCycles) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
